// ----- rtl/wind_rose_window_histogram_defines.svh -----
// ----------------------------------------------------------------------------
// Wind rose histogram assertion macros
// Concurrent checks used by the wind rose window histogram top level.
// ----------------------------------------------------------------------------
`ifndef WIND_ROSE_WINDOW_HISTOGRAM_DEFINES_SVH
`define WIND_ROSE_WINDOW_HISTOGRAM_DEFINES_SVH

`ifndef SYNTHESIS
`define WRH_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wind rose histogram check failed");
`define WRH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wind rose histogram check failed");
`else
`define WRH_ASSERT_SAME(lbl, ante, cons)
`define WRH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/wrh_pkg.sv -----
// ----------------------------------------------------------------------------
// Wind rose histogram package
// Payload structs, controller/datapath command and status, sector quantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrh_pkg;

   localparam int SECTOR_COUNT           = 16;
   localparam int SECTOR_W               = 4;
   localparam int SPEED_W                = 12;
   localparam int DIR_W                  = 9;
   localparam int COUNT_W                = 11;
   localparam int ENTRY_W                = 1 + SECTOR_W + SPEED_W;
   localparam int DEFAULT_WINDOW_DEPTH   = 1024;
   localparam int DEFAULT_RECENT_SAMPLES = 8;

   // reciprocal of 90 scaled by 2^18, exact for the 12-bit numerator range
   localparam int RECIP_90    = 2913;
   localparam int RECIP_SHIFT = 18;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                op;
      logic [DIR_W-1:0]    direction_deg;
      logic [SPEED_W-1:0]  wind_speed;
      logic [SECTOR_W-1:0] query_sector;
   } req_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sample_sector;
      logic                sample_calm;
      logic [COUNT_W-1:0]  sector_count;
      logic [SPEED_W-1:0]  sector_mean_speed;
      logic [SPEED_W-1:0]  recent_mean_speed;
      logic [COUNT_W-1:0]  largest_count;
      logic [COUNT_W-1:0]  directional_total;
      logic [COUNT_W-1:0]  window_fill;
   } rsp_type;

   typedef enum logic [1:0] {
      ADDR_EVICT,
      ADDR_NEW,
      ADDR_QUERY,
      ADDR_SWEEP
   } addr_sel_type;

   typedef struct packed {
      logic         load_item;
      logic         ring_read;
      logic         evict;
      logic         commit;
      logic         sweep_init;
      logic         sweep_step;
      logic         capture;
      logic         walk_run;
      logic         div_go;
      logic         div_recent;
      logic         rsp_load;
      addr_sel_type addr_sel;
   } cmd_type;

   typedef struct packed {
      logic req_is_query;
      logic sweep_last;
      logic walk_done;
      logic div_done;
      logic rsp_busy;
   } stat_type;

   // round(deg / 22.5) mod 16 == floor((4*deg + 45) / 90) mod 16
   function automatic logic [SECTOR_W-1:0] sector_of(input logic [DIR_W-1:0] deg);
      logic [11:0] num;
      logic [23:0] prod;
      num  = {1'b0, deg, 2'b00} + 12'd45;
      prod = {12'd0, num} * 24'(RECIP_90);
      return prod[RECIP_SHIFT +: SECTOR_W];
   endfunction

endpackage

// ----- rtl/wrh_div.sv -----
// ----------------------------------------------------------------------------
// Wind rose histogram divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrh_div #(
   parameter int W = 23
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/wrh_dpath.sv -----
// ----------------------------------------------------------------------------
// Wind rose histogram datapath
// Sample ring, sector totals, sweep, recent walk, divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrh_dpath #(
   parameter int WINDOW_DEPTH   = wrh_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int RECENT_SAMPLES = wrh_pkg::DEFAULT_RECENT_SAMPLES
) (
   input  logic              clock,
   input  logic              reset,
   input  wrh_pkg::req_type  req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output wrh_pkg::rsp_type  rsp_data,
   input  wrh_pkg::cmd_type  cmd,
   output wrh_pkg::stat_type stat
);

   import wrh_pkg::*;

   localparam int PTR_W  = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = CNT_W + SPEED_W;
   localparam int RC_W   = $clog2(RECENT_SAMPLES + 1);
   localparam int RSUM_W = SPEED_W + RC_W;
   localparam int DIV_W  = (SUM_W > RSUM_W) ? SUM_W : RSUM_W;
   localparam int CALM_BIT = ENTRY_W - 1;

   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);
   localparam logic [RC_W-1:0]  RC_LIMIT = RC_W'(RECENT_SAMPLES);

   logic [ENTRY_W-1:0] ring [WINDOW_DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   // current item
   logic                op_ff;
   logic [SPEED_W-1:0]  spd_ff;
   logic [SECTOR_W-1:0] sec_ff;
   logic                calm_ff;
   logic [SECTOR_W-1:0] q_ff;
   logic                req_calm;

   logic [PTR_W-1:0] wpos_ff, wpos_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] cnt_ff [SECTOR_COUNT];
   logic [SUM_W-1:0] sum_ff [SECTOR_COUNT];

   logic [SECTOR_W-1:0] cs_addr;
   logic [CNT_W-1:0]    cs_cnt;
   logic [SUM_W-1:0]    cs_sum;
   logic [SUM_W-1:0]    old_spd;
   logic                full;
   logic                evict_hit;

   logic [SECTOR_W-1:0] sweep_idx_ff;
   logic [CNT_W-1:0]    largest_ff;
   logic [CNT_W-1:0]    total_ff;

   logic [CNT_W-1:0] qcnt_ff;
   logic [SUM_W-1:0] qsum_ff;

   logic [PTR_W-1:0]  wpos_walk_ff, wpos_walk_in;
   logic [CNT_W-1:0]  remain_ff;
   logic [RC_W-1:0]   rcnt_ff, rcnt_in;
   logic [RSUM_W-1:0] rsum_ff;
   logic              rd_pend_ff;
   logic              take;
   logic              walk_issue;
   logic              rd_en;
   logic [PTR_W-1:0]  rd_addr;

   logic             div_recent_ff;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quotient;
   logic [SPEED_W-1:0] mean_ff;
   logic [SPEED_W-1:0] recent_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign req_calm = (req_data.direction_deg == '0) && (req_data.wind_speed == '0);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_data.op;
         spd_ff  <= req_data.wind_speed;
         calm_ff <= req_calm;
         sec_ff  <= req_calm ? '0 : sector_of(req_data.direction_deg);
         q_ff    <= req_data.query_sector;
      end
   end

   // single access port into the sector totals
   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_EVICT: cs_addr = rdata_ff[SPEED_W +: SECTOR_W];
         ADDR_NEW:   cs_addr = sec_ff;
         ADDR_QUERY: cs_addr = q_ff;
         ADDR_SWEEP: cs_addr = sweep_idx_ff;
         default:    cs_addr = sec_ff;
      endcase
   end

   assign cs_cnt    = cnt_ff[cs_addr];
   assign cs_sum    = sum_ff[cs_addr];
   assign old_spd   = SUM_W'(rdata_ff[SPEED_W-1:0]);
   assign full      = (fill_ff == FULL_CNT);
   assign evict_hit = full && !rdata_ff[CALM_BIT] && (cs_cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SECTOR_COUNT; i++) begin
            cnt_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else if (cmd.evict && evict_hit) begin
         cnt_ff[cs_addr] <= cs_cnt - 1'b1;
         sum_ff[cs_addr] <= (cs_sum >= old_spd) ? cs_sum - old_spd : '0;
      end else if (cmd.commit && !calm_ff) begin
         cnt_ff[cs_addr] <= cs_cnt + 1'b1;
         sum_ff[cs_addr] <= cs_sum + SUM_W'(spd_ff);
      end
   end

   always_comb begin
      wpos_in = wpos_ff;
      fill_in = fill_ff;
      if (cmd.commit) begin
         wpos_in = (wpos_ff == LAST_POS) ? '0 : wpos_ff + 1'b1;
         if (!full) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
         fill_ff <= '0;
      end else begin
         wpos_ff <= wpos_in;
         fill_ff <= fill_in;
      end
   end

   // newest-to-oldest walk, one ring read in flight
   assign take = cmd.walk_run && rd_pend_ff && !rdata_ff[CALM_BIT]
               && (rdata_ff[SPEED_W +: SECTOR_W] == q_ff) && (rcnt_ff != RC_LIMIT);
   assign rcnt_in    = take ? rcnt_ff + 1'b1 : rcnt_ff;
   assign walk_issue = cmd.walk_run && (remain_ff != '0) && (rcnt_in != RC_LIMIT);
   assign wpos_walk_in = (wpos_walk_ff == '0) ? LAST_POS : wpos_walk_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else if (cmd.capture) begin
         rd_pend_ff <= 1'b0;
      end else if (cmd.walk_run) begin
         rd_pend_ff <= walk_issue;
      end
      if (cmd.capture) begin
         wpos_walk_ff <= wpos_ff;
         remain_ff    <= fill_ff;
         rcnt_ff      <= '0;
         rsum_ff      <= '0;
      end else if (cmd.walk_run) begin
         rcnt_ff <= rcnt_in;
         if (take) begin
            rsum_ff <= rsum_ff + RSUM_W'(rdata_ff[SPEED_W-1:0]);
         end
         if (walk_issue) begin
            wpos_walk_ff <= wpos_walk_in;
            remain_ff    <= remain_ff - 1'b1;
         end
      end
   end

   assign rd_en   = cmd.ring_read || walk_issue;
   assign rd_addr = cmd.ring_read ? wpos_ff : wpos_walk_in;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ring[wpos_ff] <= {calm_ff, sec_ff, spd_ff};
      end
      if (rd_en) begin
         rdata_ff <= ring[rd_addr];
      end
   end

   // whole-window sweep over the sixteen sectors
   always_ff @(posedge clock) begin
      if (cmd.sweep_init) begin
         sweep_idx_ff <= '0;
         largest_ff   <= '0;
         total_ff     <= '0;
      end else if (cmd.sweep_step) begin
         sweep_idx_ff <= sweep_idx_ff + 1'b1;
         total_ff     <= total_ff + cs_cnt;
         if (cs_cnt > largest_ff) begin
            largest_ff <= cs_cnt;
         end
      end
      if (cmd.capture) begin
         qcnt_ff <= cs_cnt;
         qsum_ff <= cs_sum;
      end
   end

   assign div_dividend = cmd.div_recent ? DIV_W'(rsum_ff) : DIV_W'(qsum_ff);
   assign div_divisor  = cmd.div_recent ? DIV_W'(rcnt_ff) : DIV_W'(qcnt_ff);

   wrh_div #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_go) begin
         div_recent_ff <= cmd.div_recent;
      end
      if (div_done) begin
         if (div_recent_ff) begin
            recent_ff <= (rcnt_ff == '0) ? '0 : div_quotient[SPEED_W-1:0];
         end else begin
            mean_ff <= (qcnt_ff == '0) ? '0 : div_quotient[SPEED_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (op_ff == OP_RECORD) begin
         rsp_in.sample_sector = sec_ff;
         rsp_in.sample_calm   = calm_ff;
      end else begin
         rsp_in.sector_count      = COUNT_W'(qcnt_ff);
         rsp_in.sector_mean_speed = mean_ff;
         rsp_in.recent_mean_speed = recent_ff;
         rsp_in.largest_count     = COUNT_W'(largest_ff);
         rsp_in.directional_total = COUNT_W'(total_ff);
         rsp_in.window_fill       = COUNT_W'(fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.req_is_query = (req_data.op == OP_QUERY);
   assign stat.sweep_last   = (sweep_idx_ff == SECTOR_W'(SECTOR_COUNT - 1));
   assign stat.walk_done    = !rd_pend_ff && ((remain_ff == '0) || (rcnt_ff == RC_LIMIT));
   assign stat.div_done     = div_done;
   assign stat.rsp_busy     = rsp_valid_ff && !rsp_ready;

endmodule

// ----- rtl/wrh_ctrl.sv -----
// ----------------------------------------------------------------------------
// Wind rose histogram controller
// Sequences record and query items through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wrh_pkg::stat_type stat,
   output wrh_pkg::cmd_type  cmd
);

   import wrh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REC_READ,
      S_REC_EVICT,
      S_REC_COMMIT,
      S_Q_SWEEP,
      S_Q_CAPTURE,
      S_Q_MEAN_GO,
      S_Q_MEAN_WAIT,
      S_Q_WALK,
      S_Q_RECENT_GO,
      S_Q_RECENT_WAIT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = ADDR_NEW;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item  = 1'b1;
               cmd.sweep_init = 1'b1;
               state_in = stat.req_is_query ? S_Q_SWEEP : S_REC_READ;
            end
         end
         S_REC_READ: begin
            cmd.ring_read = 1'b1;
            state_in = S_REC_EVICT;
         end
         S_REC_EVICT: begin
            cmd.evict    = 1'b1;
            cmd.addr_sel = ADDR_EVICT;
            state_in = S_REC_COMMIT;
         end
         S_REC_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_DONE;
         end
         S_Q_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.addr_sel   = ADDR_SWEEP;
            if (stat.sweep_last) begin
               state_in = S_Q_CAPTURE;
            end
         end
         S_Q_CAPTURE: begin
            cmd.capture  = 1'b1;
            cmd.addr_sel = ADDR_QUERY;
            state_in = S_Q_MEAN_GO;
         end
         S_Q_MEAN_GO: begin
            cmd.div_go = 1'b1;
            state_in = S_Q_MEAN_WAIT;
         end
         S_Q_MEAN_WAIT: begin
            if (stat.div_done) begin
               state_in = S_Q_WALK;
            end
         end
         S_Q_WALK: begin
            cmd.walk_run = 1'b1;
            if (stat.walk_done) begin
               state_in = S_Q_RECENT_GO;
            end
         end
         S_Q_RECENT_GO: begin
            cmd.div_go     = 1'b1;
            cmd.div_recent = 1'b1;
            state_in = S_Q_RECENT_WAIT;
         end
         S_Q_RECENT_WAIT: begin
            if (stat.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ----- rtl/wind_rose_window_histogram.sv -----
// ----------------------------------------------------------------------------
// Wind rose window histogram
// Sliding-window wind histogram over sixteen direction sectors.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one beat per item: op 0 records a wind sample,
//   op 1 queries one sector. Every item gives exactly one rsp_ beat.
//   Items are handled one at a time; req_ready is high only while idle.
//   A record reads the slot it overwrites, removes that entry from its
//   sector total when the window is full, and commits the new sample.
//   A query sweeps the sector totals, runs a bit-serial division for the
//   sector mean (DIV_W = bits of the window speed sum, 23 at depth 1024),
//   walks the ring newest to oldest at one entry per cycle until
//   RECENT_SAMPLES hits or the filled window ends, then divides again.
//   The result sits in an output register; a new item is accepted while it
//   waits, and the next result loads once the receiver has taken the beat.
//   Reset clears the fill level, write pointer and all sector totals;
//   the ring itself is not cleared and no sweep runs after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wind_rose_window_histogram_defines.svh"

module wind_rose_window_histogram #(
   parameter int WINDOW_DEPTH   = wrh_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int RECENT_SAMPLES = wrh_pkg::DEFAULT_RECENT_SAMPLES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wrh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wrh_pkg::rsp_type rsp_data
);

   import wrh_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   wrh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wrh_dpath #(
      .WINDOW_DEPTH   (WINDOW_DEPTH),
      .RECENT_SAMPLES (RECENT_SAMPLES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   `WRH_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `WRH_ASSERT_SAME(a_calm_sector_zero, rsp_valid && rsp_data.sample_calm, rsp_data.sample_sector == '0 && rsp_data.window_fill == '0)
   `WRH_ASSERT_SAME(a_ring_one_access, 1'b1, $onehot0({cmd.ring_read, cmd.evict, cmd.commit, cmd.walk_run}))

endmodule

// ----- tb/wind_rose_window_histogram_tb.sv -----
// ----------------------------------------------------------------------------
// Wind rose window histogram testbench
// Drives record and query beats with random gaps and stalls, predicts each
// result from a local copy of the ring and sector totals, and checks every
// response beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wind_rose_window_histogram_tb;
   import wrh_pkg::*;

   localparam int DEPTH  = DEFAULT_WINDOW_DEPTH;
   localparam int RECENT = DEFAULT_RECENT_SAMPLES;
   localparam int STALL_LIMIT = 20000;

   class wind_scoreboard;
      logic [3:0]  ring_sec [DEPTH];
      logic        ring_calm[DEPTH];
      logic [11:0] ring_spd [DEPTH];
      int unsigned wr_pos;
      int unsigned fill;
      int unsigned sec_cnt[SECTOR_COUNT];
      longint unsigned sec_sum[SECTOR_COUNT];
      rsp_type pending[$];
      int errors;

      function new();
         wr_pos = 0;
         fill = 0;
         errors = 0;
         foreach (sec_cnt[i]) begin
            sec_cnt[i] = 0;
            sec_sum[i] = 0;
         end
      endfunction

      function void note_item(req_type r);
         rsp_type e;
         int unsigned s, p, hits, largest, total;
         longint unsigned rsum;
         logic calm;
         e = '0;
         if (r.op == OP_RECORD) begin
            calm = (r.direction_deg == 0) && (r.wind_speed == 0);
            s = calm ? 0 : ((4 * r.direction_deg + 45) / 90) % 16;
            if (fill >= DEPTH && !ring_calm[wr_pos]) begin
               p = ring_sec[wr_pos];
               if (sec_cnt[p] > 0) begin
                  sec_cnt[p]--;
                  sec_sum[p] = (sec_sum[p] >= ring_spd[wr_pos]) ?
                               sec_sum[p] - ring_spd[wr_pos] : 0;
               end
            end
            ring_sec[wr_pos]  = SECTOR_W'(s);
            ring_calm[wr_pos] = calm;
            ring_spd[wr_pos]  = r.wind_speed;
            wr_pos = (wr_pos + 1) % DEPTH;
            if (fill < DEPTH) fill++;
            if (!calm) begin
               sec_cnt[s]++;
               sec_sum[s] += r.wind_speed;
            end
            e.sample_sector = SECTOR_W'(s);
            e.sample_calm = calm;
         end else begin
            s = r.query_sector;
            p = wr_pos;
            hits = 0;
            rsum = 0;
            for (int i = 0; i < fill && hits < RECENT; i++) begin
               p = (p == 0) ? DEPTH - 1 : p - 1;
               if (!ring_calm[p] && ring_sec[p] == s) begin
                  rsum += ring_spd[p];
                  hits++;
               end
            end
            largest = 0;
            total = 0;
            foreach (sec_cnt[i]) begin
               if (sec_cnt[i] > largest) largest = sec_cnt[i];
               total += sec_cnt[i];
            end
            e.sector_count      = COUNT_W'(sec_cnt[s]);
            e.sector_mean_speed = SPEED_W'(sec_cnt[s] > 0 ? sec_sum[s] / sec_cnt[s] : 0);
            e.recent_mean_speed = SPEED_W'(hits > 0 ? rsum / hits : 0);
            e.largest_count     = COUNT_W'(largest);
            e.directional_total = COUNT_W'(total);
            e.window_fill       = COUNT_W'(fill);
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %h", a);
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: exp %p", e);
               $display("          act %p", a);
            end
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   wind_scoreboard board = new();
   bit quiet_phase = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   wind_rose_window_histogram dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_item(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // receiver: random stall bursts unless held off or in the quiet tail
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            @(posedge clock);
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send_beat(req_type r);
      int n;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 4);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_record(int unsigned deg, int unsigned spd);
      req_type r;
      r = '0;
      r.op = OP_RECORD;
      r.direction_deg = DIR_W'(deg);
      r.wind_speed = SPEED_W'(spd);
      r.query_sector = SECTOR_W'($urandom);
      send_beat(r);
   endtask

   task automatic send_query(int unsigned sec);
      req_type r;
      r = '0;
      r.op = OP_QUERY;
      r.query_sector = SECTOR_W'(sec);
      r.direction_deg = DIR_W'($urandom);
      r.wind_speed = SPEED_W'($urandom);
      send_beat(r);
   endtask

   task automatic drain_results();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned d;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty queries, sector boundaries, calm, extremes, wrap above 360
      send_query(0);
      send_query(15);
      send_record(0, 0);
      send_record(0, 4095);
      send_record(11, 16);
      send_record(12, 32);
      send_record(348, 100);
      send_record(349, 200);
      send_record(360, 4095);
      send_record(511, 1);
      send_record(90, 0);
      send_record(0, 0);
      send_record(256, 2730);
      for (int s = 0; s < 16; s++) send_query(s);

      // pause until everything has come back
      drain_results();

      // receiver holds off while sender keeps offering beats
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 6; i++) send_record($urandom_range(0, 511), $urandom);
      join

      // random: mostly records, queries mixed in
      for (int i = 0; i < 505; i++) begin
         if (i == 430) quiet_phase = 1;
         if ($urandom_range(0, 2) == 0) begin
            send_query($urandom_range(0, 15));
         end else begin
            d = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(0, 511);
            send_record(d, $urandom_range(0, 9) == 0 ? 0 : $urandom);
         end
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
